>>> src/bsrp_pkg.sv
// Shared types, constants and helpers for the branch stack record parser.
`default_nettype none

package bsrp_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned SizeW      = 16;
  localparam int unsigned RecWordsW  = 13;
  localparam int unsigned EntriesW   = 12;
  localparam int unsigned CycleW     = 16;
  localparam int unsigned KindW      = 4;
  localparam int unsigned TypeW      = 32;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [TypeW-1:0] SampleType     = 32'd9;
  localparam logic [SizeW-1:0] MinRecordBytes = 16'd8;
  localparam logic [SizeW-1:0] MinSampleBytes = 16'd32;
  localparam logic [SizeW-1:0] MaxRecordReset = 16'hFFFF;

  // floor(x/3) for x < 2^13 as (x * Div3Mul) >> Div3Shift
  localparam logic [RecWordsW-1:0] Div3Mul   = 13'd5462;
  localparam int unsigned          Div3Shift = 14;
  localparam int unsigned          Div3ProdW = 2 * RecWordsW;

  // raw branch type codes and their renumbered kinds
  localparam logic [KindW-1:0] RawLastDirect = 4'd8;
  localparam logic [KindW-1:0] RawIrq        = 4'd12;
  localparam logic [KindW-1:0] KindIrq       = 4'd9;
  localparam logic [KindW-1:0] KindUnknown   = 4'd0;

  localparam int unsigned DefaultQueueDepth = 4;

  // register map, word index within the APB window
  localparam logic RegMaxRecordBytes = 1'b0;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_SKIP_IP,
    PH_SKIP_TIME,
    PH_COUNT,
    PH_FROM,
    PH_TO,
    PH_FLAGS,
    PH_PAD,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    OP_FROM,
    OP_TO,
    OP_FLAGS,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] data;
  } cmd_t;

  function automatic logic [KindW-1:0] kind_of(input logic [KindW-1:0] raw);
    logic [KindW-1:0] k;
    if (raw <= RawLastDirect) begin
      k = raw;
    end else if (raw == RawIrq) begin
      k = KindIrq;
    end else begin
      k = KindUnknown;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/branch_stack_record_parser.sv
// A branch entry or error result is written into the command queue when its word
// transfers, then loaded into the output register once the queue head is popped.
// Throughput: one stream word per cycle; input stalls only when the command queue
// (QueueDepth entries) fills behind a stalled output register.
// Reset: asynchronous, active low; parser expects a header, queue and output
// are emptied, max_record_bytes returns to 65535.
`default_nettype none

module branch_stack_record_parser #(
  parameter int unsigned QueueDepth = bsrp_pkg::DefaultQueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsrp_pkg::AddrW-1:0]    paddr,
  input  wire logic [bsrp_pkg::DataW-1:0]    pwdata,
  output logic [bsrp_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  // word stream
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bsrp_pkg::WordW-1:0]    word_i,
  input  wire logic                          end_of_batch_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [bsrp_pkg::WordW-1:0]         from_address_o,
  output logic [bsrp_pkg::WordW-1:0]         to_address_o,
  output logic                               mispredicted_o,
  output logic                               predicted_o,
  output logic                               in_transaction_o,
  output logic                               aborted_o,
  output logic [bsrp_pkg::CycleW-1:0]        cycle_count_o,
  output logic [bsrp_pkg::KindW-1:0]         branch_kind_o
);
  import bsrp_pkg::*;

  logic [SizeW-1:0] max_record_bytes_q;
  logic             cfg_write;
  logic             reg_sel;
  logic             accept;
  logic             push_valid;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;

  // configuration register
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[AddrW-1] == RegMaxRecordBytes);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? DataW'(max_record_bytes_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_record_bytes_q <= MaxRecordReset;
    end else if (cfg_write) begin
      max_record_bytes_q <= pwdata[SizeW-1:0];
    end
  end

  // input transfer
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bsrp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .word_i             (word_i),
    .end_of_batch_i     (end_of_batch_i),
    .max_record_bytes_i (max_record_bytes_q),
    .push_valid_o       (push_valid),
    .push_cmd_o         (push_cmd)
  );

  bsrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  bsrp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .from_address_o   (from_address_o),
    .to_address_o     (to_address_o),
    .mispredicted_o   (mispredicted_o),
    .predicted_o      (predicted_o),
    .in_transaction_o (in_transaction_o),
    .aborted_o        (aborted_o),
    .cycle_count_o    (cycle_count_o),
    .branch_kind_o    (branch_kind_o)
  );

`ifndef NO_ASSERTIONS
  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_valid && q_full))
    else $error("command pushed into full queue");

  // a new result comes only from a popped flags or error command
  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(pop && ((q_cmd.op == OP_FLAGS) || (q_cmd.op == OP_ERROR))))
    else $error("result appeared without a matching command");

  // error results carry an all-zero payload
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |->
      ((from_address_o == '0) && (to_address_o == '0) && (branch_kind_o == '0)
       && (cycle_count_o == '0)))
    else $error("error result with nonzero payload");
`endif

endmodule

`default_nettype wire

>>> src/bsrp_front.sv
// Front end: accepts stream words, tracks record framing, issues commands.
`default_nettype none

module bsrp_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [bsrp_pkg::WordW-1:0]   word_i,
  input  wire logic                         end_of_batch_i,
  input  wire logic [bsrp_pkg::SizeW-1:0]   max_record_bytes_i,
  output logic                              push_valid_o,
  output bsrp_pkg::cmd_t                    push_cmd_o
);
  import bsrp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [RecWordsW-1:0]  rwl_q, rwl_d;
  logic [EntriesW-1:0]   entries_q, entries_d;

  logic [SizeW-1:0]      size;
  logic [TypeW-1:0]      rec_type;
  logic                  size_bad;
  logic [RecWordsW-1:0]  rwl_dec;
  logic [RecWordsW-1:0]  rec_words;
  logic [Div3ProdW-1:0]  fit_prod;
  logic [EntriesW-1:0]   fit;
  logic [EntriesW-1:0]   entries_cnt;
  logic [EntriesW-1:0]   ent_dec;

  // header fields and size checks
  assign size      = word_i[WordW-1 -: SizeW];
  assign rec_type  = word_i[TypeW-1:0];
  assign size_bad  = (size < MinRecordBytes) || (size > max_record_bytes_i);
  assign rec_words = RecWordsW'(size >> 3) - RecWordsW'(1);
  assign rwl_dec   = rwl_q - RecWordsW'(1);
  assign ent_dec   = entries_q - EntriesW'(1);

  // clamp the entry count to the whole triples left in the record
  assign fit_prod    = Div3ProdW'(rwl_dec) * Div3ProdW'(Div3Mul);
  assign fit         = fit_prod[Div3Shift +: EntriesW];
  assign entries_cnt = (word_i < WordW'(fit)) ? word_i[EntriesW-1:0] : fit;

  // next framing state
  always_comb begin
    phase_d   = phase_q;
    rwl_d     = rwl_q;
    entries_d = entries_q;
    if (accept_i) begin
      unique case (phase_q) inside
        PH_DISCARD: begin
        end
        PH_SKIP_IP, PH_SKIP_TIME, PH_COUNT, PH_FROM, PH_TO, PH_FLAGS, PH_PAD: begin
          rwl_d = rwl_dec;
          case (phase_q)
            PH_SKIP_IP:   phase_d = PH_SKIP_TIME;
            PH_SKIP_TIME: phase_d = PH_COUNT;
            PH_COUNT: begin
              entries_d = entries_cnt;
              phase_d   = (entries_cnt != '0) ? PH_FROM : PH_PAD;
            end
            PH_FROM:      phase_d = PH_TO;
            PH_TO:        phase_d = PH_FLAGS;
            PH_FLAGS: begin
              entries_d = ent_dec;
              phase_d   = (ent_dec != '0) ? PH_FROM : PH_PAD;
            end
            default: begin
            end
          endcase
          if (rwl_dec == '0) begin
            phase_d   = PH_HEADER;
            entries_d = '0;
          end
        end
        default: begin
          entries_d = '0;
          if (size_bad) begin
            phase_d = PH_DISCARD;
            rwl_d   = '0;
          end else begin
            rwl_d = rec_words;
            if (rec_words == '0) begin
              phase_d = PH_HEADER;
            end else if ((rec_type == SampleType) && (size >= MinSampleBytes)) begin
              phase_d = PH_SKIP_IP;
            end else begin
              phase_d = PH_PAD;
            end
          end
        end
      endcase
      // resynchronize at the batch boundary
      if (end_of_batch_i) begin
        phase_d   = PH_HEADER;
        rwl_d     = '0;
        entries_d = '0;
      end
    end
  end

  // command issued for the current word
  always_comb begin
    push_valid_o    = 1'b0;
    push_cmd_o.op   = OP_FROM;
    push_cmd_o.data = word_i;
    unique case (phase_q) inside
      PH_FROM: begin
        push_valid_o  = accept_i;
        push_cmd_o.op = OP_FROM;
      end
      PH_TO: begin
        push_valid_o  = accept_i;
        push_cmd_o.op = OP_TO;
      end
      PH_FLAGS: begin
        push_valid_o  = accept_i;
        push_cmd_o.op = OP_FLAGS;
      end
      PH_SKIP_IP, PH_SKIP_TIME, PH_COUNT, PH_PAD, PH_DISCARD: begin
      end
      default: begin
        push_valid_o  = accept_i && size_bad;
        push_cmd_o.op = OP_ERROR;
      end
    endcase
  end

  // hold framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      rwl_q     <= '0;
      entries_q <= '0;
    end else begin
      phase_q   <= phase_d;
      rwl_q     <= rwl_d;
      entries_q <= entries_d;
    end
  end

endmodule

`default_nettype wire

>>> src/bsrp_queue.sv
// Command queue between the front end and the result builder.
`default_nettype none

module bsrp_queue #(
  parameter int unsigned Depth = bsrp_pkg::DefaultQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bsrp_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bsrp_pkg::cmd_t      cmd_o
);
  import bsrp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> src/bsrp_back.sv
// Back end: holds branch addresses and builds registered result items.
`default_nettype none

module bsrp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire bsrp_pkg::cmd_t                q_cmd_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               result_kind_o,
  output logic [bsrp_pkg::WordW-1:0]         from_address_o,
  output logic [bsrp_pkg::WordW-1:0]         to_address_o,
  output logic                               mispredicted_o,
  output logic                               predicted_o,
  output logic                               in_transaction_o,
  output logic                               aborted_o,
  output logic [bsrp_pkg::CycleW-1:0]        cycle_count_o,
  output logic [bsrp_pkg::KindW-1:0]         branch_kind_o
);
  import bsrp_pkg::*;

  logic [WordW-1:0]  held_from_q;
  logic [WordW-1:0]  held_to_q;
  logic              out_valid_q, out_valid_d;
  logic              kind_q;
  logic [WordW-1:0]  from_q, to_q;
  logic [3:0]        flag_bits_q;
  logic [CycleW-1:0] cycles_q;
  logic [KindW-1:0]  bkind_q;

  logic              emits;
  logic              slot_free;
  logic              load;
  logic              is_error;

  assign is_error  = (q_cmd_i.op == OP_ERROR);
  assign emits     = (q_cmd_i.op == OP_FLAGS) || is_error;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = q_valid_i && (!emits || slot_free);
  assign load      = pop_o && emits;

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold addresses of the current triple
  always_ff @(posedge clk_i) begin
    if (pop_o && (q_cmd_i.op == OP_FROM)) begin
      held_from_q <= q_cmd_i.data;
    end
    if (pop_o && (q_cmd_i.op == OP_TO)) begin
      held_to_q <= q_cmd_i.data;
    end
  end

  // build the result; an error carries an all-zero payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_error) begin
        kind_q      <= 1'b1;
        from_q      <= '0;
        to_q        <= '0;
        flag_bits_q <= '0;
        cycles_q    <= '0;
        bkind_q     <= KindUnknown;
      end else begin
        kind_q      <= 1'b0;
        from_q      <= held_from_q;
        to_q        <= held_to_q;
        flag_bits_q <= q_cmd_i.data[3:0];
        cycles_q    <= q_cmd_i.data[4 +: CycleW];
        bkind_q     <= kind_of(q_cmd_i.data[20 +: KindW]);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign from_address_o   = from_q;
  assign to_address_o     = to_q;
  assign mispredicted_o   = flag_bits_q[0];
  assign predicted_o      = flag_bits_q[1];
  assign in_transaction_o = flag_bits_q[2];
  assign aborted_o        = flag_bits_q[3];
  assign cycle_count_o    = cycles_q;
  assign branch_kind_o    = bkind_q;

endmodule

`default_nettype wire
